### sv/uag_pkg.sv
//------------------------------------------------------------------------------
// uag_pkg
// Shared constants, types and helpers of the device allow-list guard.
//------------------------------------------------------------------------------
`default_nettype none

package uag_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_ALLOW = 2'd1;
	localparam logic [1:0] CMD_START = 2'd2;
	localparam logic [1:0] CMD_IFACE = 2'd3;

	localparam logic [2:0] REPLY_CLEARED = 3'd0;
	localparam logic [2:0] REPLY_ADDED   = 3'd1;
	localparam logic [2:0] REPLY_EXISTED = 3'd2;
	localparam logic [2:0] REPLY_FULL    = 3'd3;
	localparam logic [2:0] REPLY_VERDICT = 3'd4;

	localparam logic [7:0] CLS_PER_IFACE = 8'h00;
	localparam logic [7:0] CLS_STORAGE   = 8'h08;
	localparam logic [7:0] CLS_COMM      = 8'h02;
	localparam logic [7:0] CLS_CDC_DATA  = 8'h0A;
	localparam logic [7:0] CLS_APP       = 8'hFE;
	localparam logic [7:0] CLS_VENDOR    = 8'hFF;

	typedef struct packed {
		logic load;
		logic scan;
		logic exec;
	} ctl_cmd_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       count_zero;
		logic       idx_last;
		logic       out_busy;
	} dp_status_t;

	function automatic logic class_dangerous(input logic [7:0] cls);
		logic d;
		case (cls)
			CLS_STORAGE,
			CLS_COMM,
			CLS_CDC_DATA,
			CLS_APP,
			CLS_VENDOR: d = 1'b1;
			CLS_PER_IFACE: d = 1'b0;
			default: d = 1'b0;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

### sv/uag_ifs.sv
//------------------------------------------------------------------------------
// uag_ifs
// Request and reply channels of the device allow-list guard.
//------------------------------------------------------------------------------
`default_nettype none

interface uag_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [15:0] vendor_id;
	logic [15:0] product_id;
	logic [7:0]  class_code;
	logic        is_root_hub;
	logic        already_blocked;
	logic        is_last;

	modport source (
		output valid, command, vendor_id, product_id, class_code,
			is_root_hub, already_blocked, is_last,
		input ready
	);
	modport sink (
		input valid, command, vendor_id, product_id, class_code,
			is_root_hub, already_blocked, is_last,
		output ready
	);
endinterface

interface uag_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] reply_kind;
	logic       deny;

	modport source (output valid, reply_kind, deny, input ready);
	modport sink (input valid, reply_kind, deny, output ready);
endinterface

`default_nettype wire

### sv/uag_ctrl.sv
//------------------------------------------------------------------------------
// uag_ctrl
// Sequencer: accepts a request, scans the table when needed, then executes.
//------------------------------------------------------------------------------
`default_nettype none

module uag_ctrl
	import uag_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_ready,
	input  wire dp_status_t status,
	output ctl_cmd_t        cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DISP  = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_EXEC  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DISP;
				end
			end
			ST_DISP: begin
				if ((status.cmd == CMD_ALLOW || status.cmd == CMD_START) &&
				    !status.count_zero) begin
					state_d = ST_SCAN;
				end else begin
					state_d = ST_EXEC;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (status.idx_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (!status.out_busy) begin
					cmd.exec = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

### sv/uag_dp.sv
//------------------------------------------------------------------------------
// uag_dp
// Datapath: request registers, rule table, scan compare, device state, reply.
//------------------------------------------------------------------------------
`default_nettype none

module uag_dp
	import uag_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire ctl_cmd_t    cmd,
	output dp_status_t       status,
	input  wire logic [1:0]  command,
	input  wire logic [15:0] vendor_id,
	input  wire logic [15:0] product_id,
	input  wire logic [7:0]  class_code,
	input  wire logic        is_root_hub,
	input  wire logic        already_blocked,
	input  wire logic        is_last,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       reply_kind,
	output logic             deny
);

	logic [31:0]      mem [TABLE_ENTRIES];
	logic [31:0]      rd_data_s1;
	logic             rd_vld_s1;

	logic [1:0]       cmd_q;
	logic [15:0]      vendor_q;
	logic [15:0]      product_q;
	logic [7:0]       cls_q;
	logic             root_q;
	logic             blk_q;
	logic             last_q;

	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] idx_q;
	logic             hit_q;
	logic             exempt_q;
	logic             dang_q;
	logic             open_q;
	logic             out_valid_q;
	logic [2:0]       kind_q;
	logic             deny_q;

	logic [CNT_W-1:0] cnt_d;
	logic             exempt_d;
	logic             dang_d;
	logic             open_d;
	logic             res_vld;
	logic [2:0]       res_kind;
	logic             res_deny;
	logic             wr_en;
	logic             full;

	assign full = (count_q == CNT_W'(TABLE_ENTRIES));

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q     <= command;
			vendor_q  <= vendor_id;
			product_q <= product_id;
			cls_q     <= class_code;
			root_q    <= is_root_hub;
			blk_q     <= already_blocked;
			last_q    <= is_last;
		end
	end

	// rule table
	always_ff @(posedge clk) begin
		if (cmd.exec && wr_en) begin
			mem[count_q[IDX_W-1:0]] <= {vendor_q, product_q};
		end
		if (cmd.scan) begin
			rd_data_s1 <= mem[idx_q];
		end
	end

	always_comb begin
		cnt_d    = count_q;
		exempt_d = exempt_q;
		dang_d   = dang_q;
		open_d   = open_q;
		res_vld  = 1'b0;
		res_kind = REPLY_CLEARED;
		res_deny = 1'b0;
		wr_en    = 1'b0;
		case (cmd_q)
			CMD_CLEAR: begin
				cnt_d   = '0;
				res_vld = 1'b1;
			end
			CMD_ALLOW: begin
				res_vld = 1'b1;
				if (hit_q) begin
					res_kind = REPLY_EXISTED;
				end else if (full) begin
					res_kind = REPLY_FULL;
				end else begin
					wr_en    = 1'b1;
					cnt_d    = count_q + CNT_W'(1);
					res_kind = REPLY_ADDED;
				end
			end
			CMD_START: begin
				exempt_d = root_q | blk_q | hit_q;
				dang_d   = class_dangerous(cls_q);
				open_d   = !last_q;
				if (last_q) begin
					res_vld  = 1'b1;
					res_kind = REPLY_VERDICT;
					res_deny = !exempt_d && dang_d;
				end
			end
			default: begin
				if (open_q) begin
					dang_d = dang_q | class_dangerous(cls_q);
					if (last_q) begin
						open_d   = 1'b0;
						res_vld  = 1'b1;
						res_kind = REPLY_VERDICT;
						res_deny = !exempt_q && dang_d;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			hit_q       <= 1'b0;
			rd_vld_s1   <= 1'b0;
			exempt_q    <= 1'b0;
			dang_q      <= 1'b0;
			open_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan;
			if (cmd.load) begin
				idx_q <= '0;
				hit_q <= 1'b0;
			end else begin
				if (cmd.scan) begin
					idx_q <= idx_q + IDX_W'(1);
				end
				if (rd_vld_s1 && rd_data_s1 == {vendor_q, product_q}) begin
					hit_q <= 1'b1;
				end
			end
			if (cmd.exec) begin
				count_q  <= cnt_d;
				exempt_q <= exempt_d;
				dang_q   <= dang_d;
				open_q   <= open_d;
			end
			if (cmd.exec && res_vld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// reply register
	always_ff @(posedge clk) begin
		if (cmd.exec && res_vld) begin
			kind_q <= res_kind;
			deny_q <= res_deny;
		end
	end

	assign out_valid         = out_valid_q;
	assign reply_kind        = kind_q;
	assign deny              = deny_q;
	assign status.cmd        = cmd_q;
	assign status.count_zero = (count_q == '0);
	assign status.idx_last   = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
	assign status.out_busy   = out_valid_q && !out_ready;

endmodule

`default_nettype wire

### sv/usb_device_allowlist_guard.sv
// clear and interface items pass the dispatch and execute states to the reply
// allow and device start first scan every table entry, unless the table is empty
// one request at a time; the table holds 16 entries
// a finished reply waits in the output register while the next request is taken
// reset: asynchronous, empties the table and closes any open device
//------------------------------------------------------------------------------
// usb_device_allowlist_guard
// Allow-list check of vendor:product pairs and device classes on attach.
//------------------------------------------------------------------------------
`default_nettype none

module usb_device_allowlist_guard
	import uag_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	uag_req_if.sink  req,
	uag_rsp_if.source rsp
);

	ctl_cmd_t   cmd;
	dp_status_t status;

	uag_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.status    (status),
		.cmd       (cmd)
	);

	uag_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.command         (req.command),
		.vendor_id       (req.vendor_id),
		.product_id      (req.product_id),
		.class_code      (req.class_code),
		.is_root_hub     (req.is_root_hub),
		.already_blocked (req.already_blocked),
		.is_last         (req.is_last),
		.out_valid       (rsp.valid),
		.out_ready       (rsp.ready),
		.reply_kind      (rsp.reply_kind),
		.deny            (rsp.deny)
	);

endmodule

`default_nettype wire
